[rtl/info_frame_stuffing_encoder_macros.svh]
// ---------------------------------------------------------------------------
// Stuffing encoder assertion macros
// Shared concurrent assertion wrappers, clocked on clock.
// ---------------------------------------------------------------------------
`ifndef INFO_FRAME_STUFFING_ENCODER_MACROS_SVH
`define INFO_FRAME_STUFFING_ENCODER_MACROS_SVH

// Checked outside reset.
`define IFSE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define IFSE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/ifse_pkg.sv]
// ---------------------------------------------------------------------------
// ifse_pkg
// Types, codes and helpers of the stuffed information-frame encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package ifse_pkg;

   localparam logic [7:0] FLAG_BYTE  = 8'h7E;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] ESC_FLAG   = 8'h5E;
   localparam logic [7:0] ESC_ESC    = 8'h5D;
   localparam logic [7:0] CTRL_SEQ0  = 8'h00;
   localparam logic [7:0] CTRL_SEQ1  = 8'h40;
   localparam logic [7:0] ADDR_RESET = 8'h03;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       sequence_bit;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       frame_end;
   } rsp_item_type;

   // One classified item, handed from front to back.
   typedef struct packed {
      logic       first;     // opens a frame: header goes out first
      logic       seq;
      logic       last;
      logic [7:0] addr;
      logic [7:0] data;
      logic [7:0] check;     // payload check including this byte
   } job_type;

   typedef enum logic [3:0] {
      PH_FIRST,
      PH_ADDR,
      PH_CTRL,
      PH_HCHK,
      PH_DATA,
      PH_DATA2,
      PH_CHK,
      PH_CHK2,
      PH_FLAG
   } phase_type;

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

   function automatic logic [7:0] escaped_code(input logic [7:0] b);
      return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
   endfunction

endpackage

`default_nettype wire

[rtl/info_frame_stuffing_encoder.sv]
// ---------------------------------------------------------------------------
// info_frame_stuffing_encoder
// Byte-stuffing information-frame encoder, top level.
// ---------------------------------------------------------------------------
// Takes raw payload bytes one item at a time and produces the stuffed line
// byte stream of an information frame. The first item of a frame brings out
// the header (flag 0x7E, address, control 0x00 or 0x40 by sequence_bit, and
// address XOR control, all unstuffed); every payload byte follows, with 0x7E
// sent as 0x7D 0x5E and 0x7D as 0x7D 0x5D; the last item adds the stuffed
// XOR check of the payload and the closing flag. run_end marks the final
// line byte of each item, frame_end the closing flag. Timing: the front
// accepts one item per cycle while the job queue (QUEUE_DEPTH entries) has
// room; the back emits exactly one line byte per cycle while a job waits
// and rsp_stall is low, so an item is 1 to 9 line bytes (1 for a plain
// mid-frame byte, 2 for an escaped one, up to 4 more for a header, up to 3
// more for the trailer). The back's one-byte-per-cycle sequencer sets sustained
// throughput. The address register (reset 0x03) is written through the csr
// port, which is always ready; write it only while no frame is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module info_frame_stuffing_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire                    clock,
   input  wire                    reset,
   // payload input
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire ifse_pkg::req_item_type req_item,
   // line byte output
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output ifse_pkg::rsp_item_type rsp_item,
   // address register write
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [7:0]             csr_data
);
   import ifse_pkg::*;

   job_type push_job, head_job;
   logic    q_push, q_pop, q_empty, q_full;

   // register write never waits
   assign csr_ready = 1'b1;

   // front: classify item, keep frame state and running check
   ifse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   // decouples input acceptance from multi-byte output bursts
   ifse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   // back: one line byte per cycle into the output register, unless stalled or the queue is empty
   ifse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

[rtl/ifse_front.sv]
// ---------------------------------------------------------------------------
// ifse_front
// Accepts payload items, tracks frame state and running check, and emits
// one classified job per item into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module ifse_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire ifse_pkg::req_item_type req_item,
   input  wire                   csr_valid,
   input  wire  [7:0]            csr_data,
   input  wire                   q_full,
   output logic                  q_push,
   output ifse_pkg::job_type     q_job
);
   import ifse_pkg::*;

   logic       in_frame_ff, in_frame_in;
   logic [7:0] check_ff, check_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] check_base;

   assign req_stall  = q_full;
   assign q_push     = req_valid && !q_full;
   assign check_base = in_frame_ff ? check_ff : 8'h00;

   always_comb begin
      q_job.first = !in_frame_ff;
      q_job.seq   = req_item.sequence_bit;
      q_job.last  = req_item.last_byte;
      q_job.addr  = addr_ff;
      q_job.data  = req_item.data_byte;
      q_job.check = check_base ^ req_item.data_byte;
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      check_in    = check_ff;
      addr_in     = csr_valid ? csr_data : addr_ff;
      if (q_push) begin
         in_frame_in = !req_item.last_byte;
         check_in    = req_item.last_byte ? 8'h00 : q_job.check;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         check_ff    <= 8'h00;
         addr_ff     <= ADDR_RESET;
      end else begin
         in_frame_ff <= in_frame_in;
         check_ff    <= check_in;
         addr_ff     <= addr_in;
      end
   end

endmodule

`default_nettype wire

[rtl/ifse_queue.sv]
// ---------------------------------------------------------------------------
// ifse_queue
// Short job FIFO between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module ifse_queue #(
   parameter int DEPTH = 4
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  wire ifse_pkg::job_type push_job,
   input  wire                pop,
   output ifse_pkg::job_type  head_job,
   output logic               empty,
   output logic               full
);
   import ifse_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type              slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign head_job = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[rtl/ifse_back.sv]
// ---------------------------------------------------------------------------
// ifse_back
// Sequences the line bytes of the head job into a registered output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module ifse_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire ifse_pkg::job_type head_job,
   input  wire                    q_empty,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output ifse_pkg::rsp_item_type rsp_item
);
   import ifse_pkg::*;

   phase_type    phase_ff, phase_in, phase_cur, phase_nxt;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         emit, done, frame_close;
   logic [7:0]   line_byte, ctrl_byte;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign emit      = !q_empty && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = emit && done;
   assign ctrl_byte = head_job.seq ? CTRL_SEQ1 : CTRL_SEQ0;
   // no header for a job inside an open frame
   assign phase_cur = (phase_ff == PH_FIRST && !head_job.first) ? PH_DATA : phase_ff;

   always_comb begin
      line_byte   = FLAG_BYTE;
      done        = 1'b0;
      frame_close = 1'b0;
      phase_nxt   = phase_cur;
      unique case (phase_cur)
         PH_FIRST: begin
            line_byte = FLAG_BYTE;
            phase_nxt = PH_ADDR;
         end
         PH_ADDR: begin
            line_byte = head_job.addr;
            phase_nxt = PH_CTRL;
         end
         PH_CTRL: begin
            line_byte = ctrl_byte;
            phase_nxt = PH_HCHK;
         end
         PH_HCHK: begin
            line_byte = head_job.addr ^ ctrl_byte;
            phase_nxt = PH_DATA;
         end
         PH_DATA: begin
            if (needs_escape(head_job.data)) begin
               line_byte = ESC_BYTE;
               phase_nxt = PH_DATA2;
            end else begin
               line_byte = head_job.data;
               phase_nxt = PH_CHK;
               done      = !head_job.last;
            end
         end
         PH_DATA2: begin
            line_byte = escaped_code(head_job.data);
            phase_nxt = PH_CHK;
            done      = !head_job.last;
         end
         PH_CHK: begin
            if (needs_escape(head_job.check)) begin
               line_byte = ESC_BYTE;
               phase_nxt = PH_CHK2;
            end else begin
               line_byte = head_job.check;
               phase_nxt = PH_FLAG;
            end
         end
         PH_CHK2: begin
            line_byte = escaped_code(head_job.check);
            phase_nxt = PH_FLAG;
         end
         PH_FLAG: begin
            line_byte   = FLAG_BYTE;
            done        = 1'b1;
            frame_close = 1'b1;
         end
         default: begin
            line_byte = FLAG_BYTE;
            phase_nxt = PH_FIRST;
         end
      endcase
      if (done) begin
         phase_nxt = PH_FIRST;
      end

      phase_in     = emit ? phase_nxt : phase_ff;
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      rsp_item_in  = rsp_item_ff;
      if (emit) begin
         rsp_item_in.out_byte  = line_byte;
         rsp_item_in.run_end   = done;
         rsp_item_in.frame_end = frame_close;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

endmodule

`default_nettype wire

[rtl/ifse_checker.sv]
// ---------------------------------------------------------------------------
// ifse_checker
// Port-level assertions of the stuffing encoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "info_frame_stuffing_encoder_macros.svh"

module ifse_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input ifse_pkg::rsp_item_type rsp_item
);
   import ifse_pkg::*;

   `IFSE_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item), "stalled item changed")
   `IFSE_ASSERT(a_close_flag, rsp_valid && rsp_item.frame_end |-> rsp_item.run_end && (rsp_item.out_byte == FLAG_BYTE), "frame end not on closing flag")
   `IFSE_ASSERT(a_esc_not_last, rsp_valid && (rsp_item.out_byte == ESC_BYTE) |-> !rsp_item.run_end && !rsp_item.frame_end, "escape byte ends an item")
   `IFSE_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "output valid after reset")

endmodule

bind info_frame_stuffing_encoder ifse_checker u_checker (.*);

`default_nettype wire
